// ===== src/dem_depression_fill_top_macros.svh =====
// assertion macros for the depression fill block
`ifndef DEM_DEPRESSION_FILL_TOP_MACROS_SVH
`define DEM_DEPRESSION_FILL_TOP_MACROS_SVH

// same-cycle implication
`define DEM_FILL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DEM_FILL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dem_fill_pkg.sv =====
// shared constants, types and helpers for the depression fill block
package dem_fill_pkg;

   localparam int MAX_COLS = 256;
   localparam int MAX_ROWS = 256;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int CELL_W   = COL_W + ROW_W;
   localparam int CELL_CAP = MAX_COLS * MAX_ROWS;
   localparam int CNT_W    = CELL_W + 1;
   localparam int ELEV_W   = 32;
   localparam int CFG_W    = 9;
   localparam int IDX_W    = 2;

   localparam logic [IDX_W-1:0] REG_GRID_COLS = 2'd0;
   localparam logic [IDX_W-1:0] REG_GRID_ROWS = 2'd1;

   localparam logic [1:0] RS_READ = 2'd0;
   localparam logic [1:0] RS_CUR  = 2'd1;
   localparam logic [1:0] RS_NB   = 2'd2;

   typedef struct packed {
      logic signed [ELEV_W-1:0] spill;
      logic [CELL_W-1:0]        loc;
   } heap_ent_type;

   typedef enum logic [18:0] {
      S_IDLE      = 19'd1,
      S_RD_OUT    = 19'd2,
      S_SD_RD     = 19'd4,
      S_SD_CHK    = 19'd8,
      S_SD_NB     = 19'd16,
      S_SD_NBCHK  = 19'd32,
      S_SD_PUSH   = 19'd64,
      S_SD_NEXT   = 19'd128,
      S_PU_TEST   = 19'd256,
      S_PU_CMP    = 19'd512,
      S_PU_END    = 19'd1024,
      S_POP_CHK   = 19'd2048,
      S_POP_LD    = 19'd4096,
      S_PD_TEST   = 19'd8192,
      S_PD_CMP    = 19'd16384,
      S_PD_END    = 19'd32768,
      S_NB        = 19'd65536,
      S_NB_CHK    = 19'd131072,
      S_NB_NEXT   = 19'd262144
   } state_type;

   typedef struct packed {
      logic       req_ready;
      logic       rsp_load;
      logic [1:0] rsel;
      logic       fill_start;
      logic       latch_spill;
      logic       proc_wr;
      logic       proc_val;
      logic       proc_sel_nb;
      logic       dir_clr;
      logic       dir_inc;
      logic       cur_next;
      logic       push_seed;
      logic       push_nb;
      logic       pu_read;
      logic       pu_move;
      logic       pu_end;
      logic       pop_read;
      logic       pop_load;
      logic       pd_read;
      logic       pd_move;
      logic       pd_end;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_mode;
      logic ld_last;
      logic rsp_free;
      logic nod_q;
      logic proc_q;
      logic nb_in;
      logic dir_last;
      logic cur_last;
      logic hi_zero;
      logic par_le;
      logic heap_empty;
      logic c_out;
      logic pd_stop;
   } stat_type;

   function automatic logic signed [1:0] nb_dr(input logic [2:0] d);
      case (d)
         3'd0, 3'd1, 3'd7: nb_dr = -2'sd1;
         3'd3, 3'd4, 3'd5: nb_dr = 2'sd1;
         default:          nb_dr = 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] nb_dc(input logic [2:0] d);
      case (d)
         3'd1, 3'd2, 3'd3: nb_dc = 2'sd1;
         3'd5, 3'd6, 3'd7: nb_dc = -2'sd1;
         default:          nb_dc = 2'sd0;
      endcase
   endfunction

endpackage

// ===== src/dem_fill_if.sv =====
// handshake channel interfaces for the depression fill block
interface dem_fill_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     mode;
   logic signed [dem_fill_pkg::ELEV_W-1:0]   cell_elevation;
   logic                                     cell_is_nodata;
   modport source (output valid, mode, cell_elevation, cell_is_nodata, input ready);
   modport sink (input valid, mode, cell_elevation, cell_is_nodata, output ready);
endinterface

interface dem_fill_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [dem_fill_pkg::ELEV_W-1:0]   filled_elevation;
   logic                                     out_is_nodata;
   logic                                     last_cell;
   modport source (output valid, filled_elevation, out_is_nodata, last_cell, input ready);
   modport sink (input valid, filled_elevation, out_is_nodata, last_cell, output ready);
endinterface

interface dem_fill_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dem_fill_pkg::IDX_W-1:0]    index;
   logic [dem_fill_pkg::CFG_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/dem_fill_dp.sv =====
// datapath: grid memories, spill heap, cursors and output register
module dem_fill_dp (
   input  logic                    clock,
   input  logic                    reset,
   dem_fill_req_if.sink            req_ch,
   dem_fill_rsp_if.source          rsp_ch,
   dem_fill_csr_if.sink            csr_ch,
   input  dem_fill_pkg::cmd_type   cmd,
   output dem_fill_pkg::stat_type  stat
);

   localparam int CW = dem_fill_pkg::COL_W;
   localparam int RW = dem_fill_pkg::ROW_W;
   localparam int AW = dem_fill_pkg::CELL_W;
   localparam int NW = dem_fill_pkg::CNT_W;
   localparam int EW = dem_fill_pkg::ELEV_W;

   function automatic logic [CW:0] sat_cols(input logic [dem_fill_pkg::CFG_W-1:0] v);
      if (v == '0)
         sat_cols = (CW+1)'(1);
      else if (int'(v) > dem_fill_pkg::MAX_COLS)
         sat_cols = (CW+1)'(dem_fill_pkg::MAX_COLS);
      else
         sat_cols = (CW+1)'(v);
   endfunction

   function automatic logic [RW:0] sat_rows(input logic [dem_fill_pkg::CFG_W-1:0] v);
      if (v == '0)
         sat_rows = (RW+1)'(1);
      else if (int'(v) > dem_fill_pkg::MAX_ROWS)
         sat_rows = (RW+1)'(dem_fill_pkg::MAX_ROWS);
      else
         sat_rows = (RW+1)'(v);
   endfunction

   logic [CW:0] cols_ff, cols_in;
   logic [RW:0] rows_ff, rows_in;
   logic [RW-1:0] ld_r_ff, ld_r_in, rd_r_ff, rd_r_in, cur_r_ff, cur_r_in;
   logic [CW-1:0] ld_c_ff, ld_c_in, rd_c_ff, rd_c_in, cur_c_ff, cur_c_in;
   logic [2:0] dir_ff, dir_in;
   logic signed [EW-1:0] spill_ff, spill_in;
   logic [NW-1:0] hcnt_ff, hcnt_in;
   logic [AW-1:0] hi_ff, hi_in;
   dem_fill_pkg::heap_ent_type key_ff, key_in, last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [EW-1:0] rsp_elev_ff, rsp_elev_in;
   logic rsp_nod_ff, rsp_nod_in, rsp_last_ff, rsp_last_in;

   logic signed [EW-1:0] elev_mem [dem_fill_pkg::CELL_CAP];
   logic nod_mem [dem_fill_pkg::CELL_CAP];
   logic proc_mem [dem_fill_pkg::CELL_CAP];
   dem_fill_pkg::heap_ent_type heap_mem [dem_fill_pkg::CELL_CAP];

   logic signed [EW-1:0] elev_q;
   logic nod_q, proc_q;
   dem_fill_pkg::heap_ent_type ha_q, hb_q;

   logic signed [RW+1:0] nr;
   logic signed [CW+1:0] nc;
   logic [1:0] dr, dc;
   logic nb_in;
   logic [AW-1:0] nb_cell, cur_cell, rd_cell, ld_cell, raddr;
   logic ld_fire, csr_fire, ld_last, rd_last, cur_last;
   logic signed [EW-1:0] raised;
   logic [AW-1:0] parent, ha_addr, hb_addr;
   logic [NW-1:0] c_idx, hdec;
   logic [NW:0] c1_idx;
   logic use_b;
   dem_fill_pkg::heap_ent_type pick;
   logic [AW-1:0] pick_idx;
   logic elev_we, proc_we, heap_we;
   logic [AW-1:0] elev_wa, proc_wa;
   logic signed [EW-1:0] elev_wd;
   dem_fill_pkg::heap_ent_type heap_wd;

   assign req_ch.ready = cmd.req_ready;
   assign csr_ch.ready = cmd.req_ready;
   assign ld_fire  = req_ch.valid && cmd.req_ready && !req_ch.mode;
   assign csr_fire = csr_ch.valid && cmd.req_ready;

   assign cur_cell = {cur_r_ff, cur_c_ff};
   assign rd_cell  = {rd_r_ff, rd_c_ff};
   assign ld_cell  = {ld_r_ff, ld_c_ff};

   assign ld_last  = ({1'b0, ld_c_ff} == cols_ff - 1'b1) && ({1'b0, ld_r_ff} == rows_ff - 1'b1);
   assign rd_last  = ({1'b0, rd_c_ff} == cols_ff - 1'b1) && ({1'b0, rd_r_ff} == rows_ff - 1'b1);
   assign cur_last = ({1'b0, cur_c_ff} == cols_ff - 1'b1) &&
                     ({1'b0, cur_r_ff} == rows_ff - 1'b1);

   // neighbor of the current cell in the current direction
   assign dr = dem_fill_pkg::nb_dr(dir_ff);
   assign dc = dem_fill_pkg::nb_dc(dir_ff);
   assign nr = $signed({2'b00, cur_r_ff}) + $signed({{RW{dr[1]}}, dr});
   assign nc = $signed({2'b00, cur_c_ff}) + $signed({{CW{dc[1]}}, dc});
   assign nb_in = !nr[RW+1] && !nc[CW+1] &&
                  (nr < $signed({1'b0, rows_ff})) && (nc < $signed({1'b0, cols_ff}));
   assign nb_cell = {nr[RW-1:0], nc[CW-1:0]};

   always_comb begin
      case (cmd.rsel)
         dem_fill_pkg::RS_CUR: raddr = cur_cell;
         dem_fill_pkg::RS_NB:  raddr = nb_cell;
         default:              raddr = rd_cell;
      endcase
   end

   assign raised = (elev_q > spill_ff) ? elev_q : spill_ff;

   // heap index arithmetic
   assign parent = (hi_ff - 1'b1) >> 1;
   assign c_idx  = {hi_ff, 1'b1};
   assign c1_idx = {1'b0, c_idx} + 1'b1;
   assign hdec   = hcnt_ff - 1'b1;
   assign use_b  = (c1_idx < {1'b0, hcnt_ff}) && ($signed(hb_q.spill) < $signed(ha_q.spill));
   assign pick     = use_b ? hb_q : ha_q;
   assign pick_idx = use_b ? c1_idx[AW-1:0] : c_idx[AW-1:0];
   assign ha_addr  = cmd.pop_read ? '0 : (cmd.pu_read ? parent : c_idx[AW-1:0]);
   assign hb_addr  = cmd.pop_read ? hdec[AW-1:0] : c1_idx[AW-1:0];

   // memory write ports
   assign elev_we = ld_fire || cmd.push_nb;
   assign elev_wa = ld_fire ? ld_cell : nb_cell;
   assign elev_wd = ld_fire ? req_ch.cell_elevation : raised;
   assign proc_we = cmd.proc_wr;
   assign proc_wa = cmd.proc_sel_nb ? nb_cell : cur_cell;
   assign heap_we = cmd.pu_move || cmd.pu_end || cmd.pd_move || cmd.pd_end;

   always_comb begin
      if (cmd.pu_move)
         heap_wd = ha_q;
      else if (cmd.pu_end)
         heap_wd = key_ff;
      else if (cmd.pd_move)
         heap_wd = pick;
      else
         heap_wd = last_ff;
   end

   always_ff @(posedge clock) begin
      if (elev_we)
         elev_mem[elev_wa] <= elev_wd;
      elev_q <= elev_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (ld_fire)
         nod_mem[ld_cell] <= req_ch.cell_is_nodata;
      nod_q <= nod_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (proc_we)
         proc_mem[proc_wa] <= cmd.proc_val;
      proc_q <= proc_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (heap_we)
         heap_mem[hi_ff] <= heap_wd;
      ha_q <= heap_mem[ha_addr];
      hb_q <= heap_mem[hb_addr];
   end

   // next values
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      ld_r_in = ld_r_ff;
      ld_c_in = ld_c_ff;
      rd_r_in = rd_r_ff;
      rd_c_in = rd_c_ff;
      cur_r_in = cur_r_ff;
      cur_c_in = cur_c_ff;
      dir_in = dir_ff;
      spill_in = spill_ff;
      hcnt_in = hcnt_ff;
      hi_in = hi_ff;
      key_in = key_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_elev_in = rsp_elev_ff;
      rsp_nod_in = rsp_nod_ff;
      rsp_last_in = rsp_last_ff;

      if (csr_fire) begin
         if (csr_ch.index == dem_fill_pkg::REG_GRID_COLS) begin
            cols_in = sat_cols(csr_ch.data);
         end
         if (csr_ch.index == dem_fill_pkg::REG_GRID_ROWS) begin
            rows_in = sat_rows(csr_ch.data);
         end
         if (csr_ch.index == dem_fill_pkg::REG_GRID_COLS ||
             csr_ch.index == dem_fill_pkg::REG_GRID_ROWS) begin
            ld_r_in = '0;
            ld_c_in = '0;
            rd_r_in = '0;
            rd_c_in = '0;
         end
      end

      if (ld_fire) begin
         if (ld_last) begin
            ld_r_in = '0;
            ld_c_in = '0;
            rd_r_in = '0;
            rd_c_in = '0;
         end else if ({1'b0, ld_c_ff} == cols_ff - 1'b1) begin
            ld_c_in = '0;
            ld_r_in = ld_r_ff + 1'b1;
         end else begin
            ld_c_in = ld_c_ff + 1'b1;
         end
      end

      if (cmd.fill_start) begin
         cur_r_in = '0;
         cur_c_in = '0;
         hcnt_in = '0;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_elev_in = elev_q;
         rsp_nod_in = nod_q;
         rsp_last_in = rd_last;
         if (rd_last) begin
            rd_r_in = '0;
            rd_c_in = '0;
         end else if ({1'b0, rd_c_ff} == cols_ff - 1'b1) begin
            rd_c_in = '0;
            rd_r_in = rd_r_ff + 1'b1;
         end else begin
            rd_c_in = rd_c_ff + 1'b1;
         end
      end

      if (cmd.latch_spill)
         spill_in = elev_q;
      if (cmd.dir_clr)
         dir_in = '0;
      if (cmd.dir_inc)
         dir_in = dir_ff + 1'b1;

      if (cmd.cur_next) begin
         if ({1'b0, cur_c_ff} == cols_ff - 1'b1) begin
            cur_c_in = '0;
            cur_r_in = cur_r_ff + 1'b1;
         end else begin
            cur_c_in = cur_c_ff + 1'b1;
         end
      end

      if (cmd.push_seed) begin
         key_in = '{spill: spill_ff, loc: cur_cell};
         hi_in = hcnt_ff[AW-1:0];
         hcnt_in = hcnt_ff + 1'b1;
      end
      if (cmd.push_nb) begin
         key_in = '{spill: raised, loc: nb_cell};
         hi_in = hcnt_ff[AW-1:0];
         hcnt_in = hcnt_ff + 1'b1;
      end
      if (cmd.pu_move)
         hi_in = parent;

      if (cmd.pop_read) begin
         hcnt_in = hdec;
         hi_in = '0;
      end
      if (cmd.pop_load) begin
         spill_in = ha_q.spill;
         cur_r_in = ha_q.loc[AW-1:CW];
         cur_c_in = ha_q.loc[CW-1:0];
         last_in = hb_q;
      end
      if (cmd.pd_move)
         hi_in = pick_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= sat_cols(dem_fill_pkg::CFG_W'(256));
         rows_ff <= sat_rows(dem_fill_pkg::CFG_W'(256));
         ld_r_ff <= '0;
         ld_c_ff <= '0;
         rd_r_ff <= '0;
         rd_c_ff <= '0;
         hcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         ld_r_ff <= ld_r_in;
         ld_c_ff <= ld_c_in;
         rd_r_ff <= rd_r_in;
         rd_c_ff <= rd_c_in;
         hcnt_ff <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_r_ff <= cur_r_in;
      cur_c_ff <= cur_c_in;
      dir_ff <= dir_in;
      spill_ff <= spill_in;
      hi_ff <= hi_in;
      key_ff <= key_in;
      last_ff <= last_in;
      rsp_elev_ff <= rsp_elev_in;
      rsp_nod_ff <= rsp_nod_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.filled_elevation = rsp_elev_ff;
   assign rsp_ch.out_is_nodata = rsp_nod_ff;
   assign rsp_ch.last_cell = rsp_last_ff;

   always_comb begin
      stat.req_valid  = req_ch.valid;
      stat.req_mode   = req_ch.mode;
      stat.ld_last    = ld_last;
      stat.rsp_free   = !rsp_valid_ff || rsp_ch.ready;
      stat.nod_q      = nod_q;
      stat.proc_q     = proc_q;
      stat.nb_in      = nb_in;
      stat.dir_last   = (dir_ff == 3'd7);
      stat.cur_last   = cur_last;
      stat.hi_zero    = (hi_ff == '0);
      stat.par_le     = $signed(ha_q.spill) <= $signed(key_ff.spill);
      stat.heap_empty = (hcnt_ff == '0);
      stat.c_out      = (c_idx >= hcnt_ff);
      stat.pd_stop    = $signed(pick.spill) >= $signed(last_ff.spill);
   end

endmodule

// ===== src/dem_fill_ctrl.sv =====
// controller: sequencing of load, readout, seeding, heap and flood steps
module dem_fill_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  dem_fill_pkg::stat_type  stat,
   output dem_fill_pkg::cmd_type   cmd
);

   dem_fill_pkg::state_type state_ff, state_in;
   logic ret_nb_ff, ret_nb_in;

   always_comb begin
      state_in = state_ff;
      ret_nb_in = ret_nb_ff;
      cmd = '0;
      cmd.rsel = dem_fill_pkg::RS_READ;
      case (state_ff)
         dem_fill_pkg::S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (stat.req_valid) begin
               if (stat.req_mode) begin
                  state_in = dem_fill_pkg::S_RD_OUT;
               end else if (stat.ld_last) begin
                  cmd.fill_start = 1'b1;
                  state_in = dem_fill_pkg::S_SD_RD;
               end
            end
         end
         dem_fill_pkg::S_RD_OUT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = dem_fill_pkg::S_IDLE;
            end
         end
         dem_fill_pkg::S_SD_RD: begin
            cmd.rsel = dem_fill_pkg::RS_CUR;
            state_in = dem_fill_pkg::S_SD_CHK;
         end
         dem_fill_pkg::S_SD_CHK: begin
            cmd.latch_spill = 1'b1;
            if (stat.nod_q) begin
               cmd.proc_wr = 1'b1;
               cmd.proc_val = 1'b1;
               state_in = dem_fill_pkg::S_SD_NEXT;
            end else begin
               cmd.dir_clr = 1'b1;
               state_in = dem_fill_pkg::S_SD_NB;
            end
         end
         dem_fill_pkg::S_SD_NB: begin
            cmd.rsel = dem_fill_pkg::RS_NB;
            state_in = stat.nb_in ? dem_fill_pkg::S_SD_NBCHK : dem_fill_pkg::S_SD_PUSH;
         end
         dem_fill_pkg::S_SD_NBCHK: begin
            if (stat.nod_q) begin
               state_in = dem_fill_pkg::S_SD_PUSH;
            end else if (stat.dir_last) begin
               cmd.proc_wr = 1'b1;
               state_in = dem_fill_pkg::S_SD_NEXT;
            end else begin
               cmd.dir_inc = 1'b1;
               state_in = dem_fill_pkg::S_SD_NB;
            end
         end
         dem_fill_pkg::S_SD_PUSH: begin
            cmd.proc_wr = 1'b1;
            cmd.proc_val = 1'b1;
            cmd.push_seed = 1'b1;
            ret_nb_in = 1'b0;
            state_in = dem_fill_pkg::S_PU_TEST;
         end
         dem_fill_pkg::S_SD_NEXT: begin
            if (stat.cur_last) begin
               state_in = dem_fill_pkg::S_POP_CHK;
            end else begin
               cmd.cur_next = 1'b1;
               state_in = dem_fill_pkg::S_SD_RD;
            end
         end
         dem_fill_pkg::S_PU_TEST: begin
            if (stat.hi_zero) begin
               state_in = dem_fill_pkg::S_PU_END;
            end else begin
               cmd.pu_read = 1'b1;
               state_in = dem_fill_pkg::S_PU_CMP;
            end
         end
         dem_fill_pkg::S_PU_CMP: begin
            if (stat.par_le) begin
               state_in = dem_fill_pkg::S_PU_END;
            end else begin
               cmd.pu_move = 1'b1;
               state_in = dem_fill_pkg::S_PU_TEST;
            end
         end
         dem_fill_pkg::S_PU_END: begin
            cmd.pu_end = 1'b1;
            state_in = ret_nb_ff ? dem_fill_pkg::S_NB_NEXT : dem_fill_pkg::S_SD_NEXT;
         end
         dem_fill_pkg::S_POP_CHK: begin
            if (stat.heap_empty) begin
               state_in = dem_fill_pkg::S_IDLE;
            end else begin
               cmd.pop_read = 1'b1;
               state_in = dem_fill_pkg::S_POP_LD;
            end
         end
         dem_fill_pkg::S_POP_LD: begin
            cmd.pop_load = 1'b1;
            state_in = dem_fill_pkg::S_PD_TEST;
         end
         dem_fill_pkg::S_PD_TEST: begin
            if (stat.c_out) begin
               state_in = dem_fill_pkg::S_PD_END;
            end else begin
               cmd.pd_read = 1'b1;
               state_in = dem_fill_pkg::S_PD_CMP;
            end
         end
         dem_fill_pkg::S_PD_CMP: begin
            if (stat.pd_stop) begin
               state_in = dem_fill_pkg::S_PD_END;
            end else begin
               cmd.pd_move = 1'b1;
               state_in = dem_fill_pkg::S_PD_TEST;
            end
         end
         dem_fill_pkg::S_PD_END: begin
            cmd.pd_end = 1'b1;
            cmd.dir_clr = 1'b1;
            state_in = dem_fill_pkg::S_NB;
         end
         dem_fill_pkg::S_NB: begin
            cmd.rsel = dem_fill_pkg::RS_NB;
            state_in = stat.nb_in ? dem_fill_pkg::S_NB_CHK : dem_fill_pkg::S_NB_NEXT;
         end
         dem_fill_pkg::S_NB_CHK: begin
            if (stat.proc_q) begin
               state_in = dem_fill_pkg::S_NB_NEXT;
            end else begin
               cmd.proc_wr = 1'b1;
               cmd.proc_val = 1'b1;
               cmd.proc_sel_nb = 1'b1;
               cmd.push_nb = 1'b1;
               ret_nb_in = 1'b1;
               state_in = dem_fill_pkg::S_PU_TEST;
            end
         end
         dem_fill_pkg::S_NB_NEXT: begin
            if (stat.dir_last) begin
               state_in = dem_fill_pkg::S_POP_CHK;
            end else begin
               cmd.dir_inc = 1'b1;
               state_in = dem_fill_pkg::S_NB;
            end
         end
         default: begin
            state_in = dem_fill_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dem_fill_pkg::S_IDLE;
         ret_nb_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_nb_ff <= ret_nb_in;
      end
   end

endmodule

// ===== src/dem_depression_fill_top.sv =====
// top level of the elevation grid depression fill block
//
//   channel  dir  beat contents
//   req_ch   in   mode, cell_elevation, cell_is_nodata
//   rsp_ch   out  filled_elevation, out_is_nodata, last_cell
//   csr_ch   in   index, data (grid_cols = 0, grid_rows = 1)
//
// load beats go back to back into the grid memories; a read beat passes the registered grid
// memory read and waits for a free output register; the beat that loads the last cell
// starts the fill: a seeding sweep over every cell, then heap pops, each with a sift-down
// and a visit of the eight neighbor directions; every heap push sifts up the heap
// no beats are taken during the fill; csr writes are taken only while idle
// reset is synchronous; grid memories hold no reset and are rebuilt by loading
// a finished read beat waits in the output register while the next beat is taken
`include "dem_depression_fill_top_macros.svh"

module dem_depression_fill_top (
   input logic             clock,
   input logic             reset,
   dem_fill_req_if.sink    req_ch,
   dem_fill_rsp_if.source  rsp_ch,
   dem_fill_csr_if.sink    csr_ch
);

   dem_fill_pkg::cmd_type  cmd;
   dem_fill_pkg::stat_type stat;

   dem_fill_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   dem_fill_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .stat   (stat)
   );

   `DEM_FILL_ASSERT_NEXT(a_read_busy, clock, reset, req_ch.valid && req_ch.ready && req_ch.mode, !req_ch.ready, "read beat did not hold off the next beat")
   `DEM_FILL_ASSERT_NEXT(a_fill_busy, clock, reset, cmd.fill_start, !csr_ch.ready && !req_ch.ready, "fill started but channels still open")
   `DEM_FILL_ASSERT_NOW(a_load_sync, clock, reset, cmd.rsp_load, !req_ch.ready, "output load while taking beats")

endmodule
